@@ rtl/pffl_pkg.sv @@
// shared constants, codes and command/status types of the page frame allocator
// no dependencies

package pffl_pkg;

    // sizing
    localparam int NUM_FRAMES = 4096;
    localparam int PID_BITS   = 16;
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int PID_W      = 16;
    localparam int STACK_AW   = $clog2(NUM_FRAMES);
    localparam int OWNER_W    = PID_BITS + 1;
    localparam int CFG_IDX_W  = 1;

    // request kinds
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_SEED  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EVEN  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 1'b1;

    localparam logic [COUNT_W-1:0] TOP_RESET = COUNT_W'(NUM_FRAMES);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
        logic clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } sts_t;

endpackage

@@ rtl/pffl_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module pffl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/pffl_ctrl.sv @@
// controller state machine: clearing pass, idle, execute
// depends on pffl_pkg

module pffl_ctrl
    import pffl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.finish = 1'b1;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pffl_datapath.sv @@
// datapath: config registers, stack count, range checks, stack and owner rams
// depends on pffl_pkg and pffl_ram

module pffl_datapath
    import pffl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [1:0]           req_type,
    input  logic [FRAME_W-1:0]   frame_number,
    input  logic [PID_W-1:0]     pid,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    output logic [1:0]           status,
    output logic [FRAME_W-1:0]   alloc_frame,
    output logic [COUNT_W-1:0]   free_count
);

    localparam logic [COUNT_W-1:0] NUM_C = COUNT_W'(NUM_FRAMES);

    logic [COUNT_W-1:0]  first_reg;
    logic [COUNT_W-1:0]  top_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic                alloc_ok_reg;
    logic [PID_BITS-1:0] pid_reg;
    logic [STACK_AW-1:0] clr_cnt_reg;

    logic [COUNT_W-1:0]  frame_ext;
    logic [COUNT_W-1:0]  cnt_dec;
    logic                in_range;
    logic                push_req;
    logic                push_ok;
    logic                pop_ok;

    logic                stk_we;
    logic [STACK_AW-1:0] stk_wr_addr;
    logic [STACK_AW-1:0] stk_rd_addr;
    logic [FRAME_W-1:0]  stk_rd_data;

    logic                own_we;
    logic [STACK_AW-1:0] own_addr;
    logic [OWNER_W-1:0]  own_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            top_reg   <= TOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST: first_reg <= cfg_data;
                CFG_TOP:   top_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    // request decode and range check
    always_comb
    begin
        frame_ext = {{(COUNT_W-FRAME_W){1'b0}}, frame_number};
        cnt_dec   = count_reg - COUNT_W'(1);
        in_range  = (frame_ext >= first_reg) && (frame_ext < top_reg)
                    && (frame_ext < NUM_C) && (count_reg < NUM_C);
        push_req  = (req_type == REQ_FREE)
                    || ((req_type == REQ_SEED) && frame_number[0]);
        push_ok   = push_req && in_range;
        pop_ok    = (req_type == REQ_ALLOC) && (count_reg != '0);

        priority if (req_type == REQ_ALLOC)
        begin
            status_next = pop_ok ? ST_OK : ST_EMPTY;
        end
        else if ((req_type == REQ_SEED) && !frame_number[0])
        begin
            status_next = ST_EVEN;
        end
        else if (push_req)
        begin
            status_next = in_range ? ST_OK : ST_RANGE;
        end
        else
        begin
            status_next = ST_RANGE;
        end

        priority if (pop_ok)
        begin
            count_next = cnt_dec;
        end
        else if (push_ok)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                count_reg <= count_next;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + STACK_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg   <= status_next;
            alloc_ok_reg <= pop_ok;
            pid_reg      <= pid[PID_BITS-1:0];
        end
    end

    assign sts.clr_last = (clr_cnt_reg == STACK_AW'(NUM_FRAMES - 1));

    // stack ram: push writes at count, pop reads at count minus one
    assign stk_we      = cmd.accept && push_ok;
    assign stk_wr_addr = count_reg[STACK_AW-1:0];
    assign stk_rd_addr = cnt_dec[STACK_AW-1:0];

    pffl_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_FRAMES)
    ) u_stack_ram (
        .clk     (clk),
        .we      (stk_we),
        .wr_addr (stk_wr_addr),
        .wr_data (frame_number),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // owner ram entry is {valid, pid}
    always_comb
    begin
        own_we   = 1'b0;
        own_addr = clr_cnt_reg;
        own_data = '0;
        priority if (cmd.clear)
        begin
            own_we = 1'b1;
        end
        else if (cmd.accept && push_ok)
        begin
            own_we   = 1'b1;
            own_addr = frame_number[STACK_AW-1:0];
        end
        else if (cmd.finish && alloc_ok_reg)
        begin
            own_we   = 1'b1;
            own_addr = stk_rd_data[STACK_AW-1:0];
            own_data = {1'b1, pid_reg};
        end
        else
        begin
            own_we = 1'b0;
        end
    end

    pffl_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (NUM_FRAMES)
    ) u_owner_ram (
        .clk     (clk),
        .we      (own_we),
        .wr_addr (own_addr),
        .wr_data (own_data),
        .rd_addr (own_addr),
        .rd_data ()
    );

    assign status      = status_reg;
    assign alloc_frame = (cmd.finish && alloc_ok_reg) ? stk_rd_data : '0;
    assign free_count  = count_reg;

endmodule

@@ rtl/page_frame_free_list_allocator.sv @@
// top level of the lifo page frame allocator: controller plus datapath
// depends on pffl_pkg, pffl_ctrl, pffl_datapath (and pffl_ram below it)

// A request beat is taken when start is high and busy is low; its result is
// shown for exactly one cycle with done high, in the cycle after the request,
// and the receiver cannot stall it. A request holds busy high through its
// result beat: the stack and owner memories have a registered read, so a
// popped frame is only available in the cycle after the request, where its
// owner entry is written. After reset the owner table is swept to unowned,
// one entry a cycle, with busy held high; configuration writes are accepted
// throughout, cfg_ready is always high.

module page_frame_free_list_allocator
    import pffl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request beat
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [FRAME_W-1:0]   frame_number,
    input  logic [PID_W-1:0]     pid,
    // result beat
    output logic                 done,
    output logic [1:0]           status,
    output logic [FRAME_W-1:0]   alloc_frame,
    output logic [COUNT_W-1:0]   free_count,
    // register write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pffl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pffl_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .frame_number (frame_number),
        .pid          (pid),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .alloc_frame  (alloc_frame),
        .free_count   (free_count)
    );

    // every accepted request gets its result beat in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result beat missing after request");

    // a result beat only ever follows an accepted request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result beat without request");

    // the free count only moves when a request is taken
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> $stable(free_count))
        else $error("free count changed without request");

    // the stack never holds more than every frame
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count <= COUNT_W'(NUM_FRAMES))
        else $error("free count beyond frame total");

    // an empty report leaves the stack empty
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (free_count == '0))
        else $error("empty status with frames on stack");

endmodule

@@ test/tb.sv @@
// self-checking testbench for page_frame_free_list_allocator
// depends on pffl_pkg and the rtl of the allocator; holds its own free-stack predictor

module tb;
    import pffl_pkg::*;

    // no package name for the unused request kind
    localparam logic [1:0] REQ_BAD = 2'd3;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 310;

    // one result beat as the block presents it
    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] alloc_frame;
        logic [COUNT_W-1:0] free_count;
    } grant_t;

    // directed plan: request rows and register rows
    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [1:0]         req;
        logic [FRAME_W-1:0] frame;
        logic [PID_W-1:0]   who;
        bit                 typed;
        grant_t             want;
        logic [COUNT_W-1:0] lo;
        logic [COUNT_W-1:0] hi;
    } plan_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [1:0]           req_type     = REQ_ALLOC;
    logic [FRAME_W-1:0]   frame_number = '0;
    logic [PID_W-1:0]     pid          = '0;
    logic                 done;
    logic [1:0]           status;
    logic [FRAME_W-1:0]   alloc_frame;
    logic [COUNT_W-1:0]   free_count;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_FIRST;
    logic [COUNT_W-1:0]   cfg_data     = '0;

    // predictor state: free stack, owner table, window registers
    logic [FRAME_W-1:0] free_frames [NUM_FRAMES];
    int unsigned        stack_depth = 0;
    logic [PID_W-1:0]   owner_of [NUM_FRAMES];
    bit                 owned [NUM_FRAMES];
    logic [COUNT_W-1:0] lo_frame = '0;
    logic [COUNT_W-1:0] hi_frame = TOP_RESET;

    grant_t    due_grants [$];
    plan_row_t plan [$];
    int        mismatches  = 0;
    int        cycle_count = 0;

    page_frame_free_list_allocator dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, well beyond the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, due_grants.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // a push of one frame, shared by free and by seed of an odd frame
    function automatic logic [1:0] push_frame(input logic [FRAME_W-1:0] f);
        if (f < lo_frame || f >= hi_frame || f >= NUM_FRAMES)
            return ST_RANGE;
        if (stack_depth >= NUM_FRAMES)
            return ST_RANGE;
        owned[f]                              = 1'b0;
        owner_of[f]                           = '0;
        free_frames[FRAME_W'(stack_depth)]    = f;
        stack_depth++;
        return ST_OK;
    endfunction

    // outcome of one request, updating the predicted stack and owners
    function automatic grant_t predict_grant(input logic [1:0] kind,
                                             input logic [FRAME_W-1:0] f,
                                             input logic [PID_W-1:0] who);
        grant_t r;
        r = '0;
        case (kind)
            REQ_ALLOC:
            begin
                if (stack_depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    stack_depth--;
                    r.alloc_frame          = free_frames[FRAME_W'(stack_depth)];
                    owner_of[r.alloc_frame] = who;
                    owned[r.alloc_frame]    = 1'b1;
                end
            end
            REQ_FREE:
                r.status = push_frame(f);
            REQ_SEED:
                // parity is checked ahead of the window
                r.status = f[0] ? push_frame(f) : ST_EVEN;
            default:
                r.status = ST_RANGE;
        endcase
        r.free_count = COUNT_W'(stack_depth);
        return r;
    endfunction

    // result side: every done beat is matched against the oldest expectation
    always @(posedge clk)
    begin : grant_check
        grant_t exp_g;
        if (rst_n && done)
        begin
            if (due_grants.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (status %0d frame %0d count %0d)",
                         $time, status, alloc_frame, free_count);
                mismatches++;
            end
            else
            begin
                exp_g = due_grants.pop_front();
                if (status !== exp_g.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, exp_g.status, status);
                    mismatches++;
                end
                if (alloc_frame !== exp_g.alloc_frame)
                begin
                    $display("%0t: alloc_frame expected %0d got %0d",
                             $time, exp_g.alloc_frame, alloc_frame);
                    mismatches++;
                end
                if (free_count !== exp_g.free_count)
                begin
                    $display("%0t: free_count expected %0d got %0d",
                             $time, exp_g.free_count, free_count);
                    mismatches++;
                end
            end
        end
    end

    // mostly back-to-back beats, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic grant_t mk_grant(input logic [1:0] st, input logic [FRAME_W-1:0] af,
                                        input logic [COUNT_W-1:0] fc);
        grant_t g;
        g.status      = st;
        g.alloc_frame = af;
        g.free_count  = fc;
        return g;
    endfunction

    // row whose result is written down by hand
    function automatic void row_typed(input logic [1:0] kind, input logic [FRAME_W-1:0] f,
                                      input logic [PID_W-1:0] who, input logic [1:0] st,
                                      input logic [FRAME_W-1:0] af,
                                      input logic [COUNT_W-1:0] fc);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.req   = kind;
        r.frame = f;
        r.who   = who;
        r.typed = 1'b1;
        r.want  = mk_grant(st, af, fc);
        plan.push_back(r);
    endfunction

    // row left to the predictor
    function automatic void row_predicted(input logic [1:0] kind, input logic [FRAME_W-1:0] f,
                                          input logic [PID_W-1:0] who);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.req   = kind;
        r.frame = f;
        r.who   = who;
        plan.push_back(r);
    endfunction

    function automatic void row_config(input logic [COUNT_W-1:0] lo, input logic [COUNT_W-1:0] hi);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.lo   = lo;
        r.hi   = hi;
        plan.push_back(r);
    endfunction

    // one request beat; start is left high so the next beat can follow at once
    task automatic issue(input logic [1:0] kind, input logic [FRAME_W-1:0] f,
                         input logic [PID_W-1:0] who, input bit typed, input grant_t want);
        grant_t g;
        start        <= 1'b1;
        req_type     <= kind;
        frame_number <= f;
        pid          <= who;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        g = predict_grant(kind, f, who);
        due_grants.push_back(typed ? want : g);
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // sender holds off until every outstanding result has arrived
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (due_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_FIRST)
            lo_frame = val;
        else
            hi_frame = val;
    endtask

    // both window registers back to back, valid dropped only after the second beat
    task automatic set_config(input logic [COUNT_W-1:0] lo, input logic [COUNT_W-1:0] hi);
        write_reg(CFG_FIRST, lo);
        write_reg(CFG_TOP, hi);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         lo_i;
        int         hi_i;
        int         alloc_w;
        int         roll;
        bit         burst;
        logic [1:0] kind;
        logic [FRAME_W-1:0] f;
        logic [COUNT_W-1:0] first_v;
        logic [COUNT_W-1:0] top_v;

        // reset window: full range, empty stack
        row_typed(REQ_ALLOC, 12'd0, 16'h0000, ST_EMPTY, 12'd0, 13'd0);
        row_typed(REQ_BAD, 12'hFFF, 16'hFFFF, ST_RANGE, 12'd0, 13'd0);
        row_typed(REQ_SEED, 12'd0, 16'h0000, ST_EVEN, 12'd0, 13'd0);
        row_typed(REQ_SEED, 12'hFFF, 16'h0000, ST_OK, 12'd0, 13'd1);
        row_typed(REQ_FREE, 12'd0, 16'h0000, ST_OK, 12'd0, 13'd2);
        row_typed(REQ_FREE, 12'hFFF, 16'h0000, ST_OK, 12'd0, 13'd3);
        // last in, first out; frame field ignored on allocate
        row_typed(REQ_ALLOC, 12'd0, 16'hFFFF, ST_OK, 12'hFFF, 13'd2);
        row_typed(REQ_ALLOC, 12'd0, 16'h0000, ST_OK, 12'd0, 13'd1);
        row_typed(REQ_ALLOC, 12'hABC, 16'h1234, ST_OK, 12'hFFF, 13'd0);
        row_typed(REQ_ALLOC, 12'd0, 16'h5555, ST_EMPTY, 12'd0, 13'd0);
        // narrow window, both edges
        row_config(13'd100, 13'd200);
        row_typed(REQ_FREE, 12'd99, 16'h0000, ST_RANGE, 12'd0, 13'd0);
        row_typed(REQ_FREE, 12'd100, 16'h0000, ST_OK, 12'd0, 13'd1);
        row_typed(REQ_FREE, 12'd199, 16'h0000, ST_OK, 12'd0, 13'd2);
        row_typed(REQ_FREE, 12'd200, 16'h0000, ST_RANGE, 12'd0, 13'd2);
        row_typed(REQ_SEED, 12'd101, 16'h0000, ST_OK, 12'd0, 13'd3);
        row_typed(REQ_SEED, 12'd201, 16'h0000, ST_RANGE, 12'd0, 13'd3);
        // even seed outside the window still reports the skip
        row_typed(REQ_SEED, 12'd98, 16'h0000, ST_EVEN, 12'd0, 13'd3);
        row_predicted(REQ_ALLOC, 12'd0, 16'h00AA);
        row_predicted(REQ_BAD, 12'd150, 16'h0007);
        // inverted extremes: nothing can be freed
        row_config(13'd4096, 13'd0);
        row_typed(REQ_FREE, 12'd150, 16'h0000, ST_RANGE, 12'd0, 13'd2);
        row_typed(REQ_SEED, 12'hFFF, 16'h0000, ST_RANGE, 12'd0, 13'd2);
        row_predicted(REQ_ALLOC, 12'd0, 16'h8000);
        row_predicted(REQ_ALLOC, 12'd0, 16'h0001);
        row_typed(REQ_ALLOC, 12'd0, 16'h0000, ST_EMPTY, 12'd0, 13'd0);
        row_config(13'd0, 13'd4096);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part; the first beat waits out the owner clearing sweep
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                set_config(plan[i].lo, plan[i].hi);
            end
            else
            begin
                issue(plan[i].req, plan[i].frame, plan[i].who, plan[i].typed, plan[i].want);
                pause(pick_gap());
            end
        end

        // random phases, each under its own window
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            case (ph % 4)
                0:
                begin
                    first_v = 13'd0;
                    top_v   = TOP_RESET;
                end
                1:
                begin
                    first_v = COUNT_W'($urandom_range(0, 2048));
                    top_v   = COUNT_W'($urandom_range(int'(first_v), 4096));
                end
                2:
                begin
                    // tiny window, frames recycled often
                    first_v = COUNT_W'($urandom_range(0, 8));
                    top_v   = COUNT_W'($urandom_range(8, 64));
                end
                default:
                begin
                    first_v = COUNT_W'($urandom_range(0, 4096));
                    top_v   = COUNT_W'($urandom_range(0, 4096));
                end
            endcase
            set_config(first_v, top_v);
            lo_i    = int'(lo_frame);
            hi_i    = (int'(hi_frame) > NUM_FRAMES) ? NUM_FRAMES : int'(hi_frame);
            alloc_w = (ph % 2 == 0) ? 55 : 40;
            burst   = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                f    = FRAME_W'($urandom_range(0, 4095));
                if (roll < alloc_w)
                    kind = REQ_ALLOC;
                else if (roll < 75)
                begin
                    kind = REQ_FREE;
                    if (lo_i < hi_i)
                        f = FRAME_W'($urandom_range(lo_i, hi_i - 1));
                end
                else if (roll < 90)
                begin
                    kind = REQ_SEED;
                    if (lo_i < hi_i)
                        f = FRAME_W'($urandom_range(lo_i, hi_i - 1));
                end
                else if (roll < 95)
                    kind = REQ_FREE;
                else
                    kind = REQ_BAD;
                issue(kind, f, PID_W'($urandom()), 1'b0, '0);
                pause(burst ? 0 : pick_gap());
            end
        end

        // a last few allocations and frees back to back over the full window
        settle();
        set_config(13'd0, TOP_RESET);
        for (int n = 0; n < 6; n++)
            issue(REQ_ALLOC, 12'd0, PID_W'($urandom()), 1'b0, '0);
        issue(REQ_FREE, 12'd77, 16'h0000, 1'b0, '0);
        issue(REQ_FREE, 12'd78, 16'h0000, 1'b0, '0);

        // drain, then a few quiet cycles for any stray beat
        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
